/* design/grid_route_cost_with_turn_penalty_defines.svh */
// ---------------------------------------------------------------------------
// Grid route cost assertion macros
// Shared property templates for the block checker.
// ---------------------------------------------------------------------------
`ifndef GRID_ROUTE_COST_WITH_TURN_PENALTY_DEFINES_SVH
`define GRID_ROUTE_COST_WITH_TURN_PENALTY_DEFINES_SVH

// same-cycle implication
`define GRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grc check failed");

// next-cycle implication
`define GRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grc check failed");

`endif

/* design/grc_pkg.sv */
// ---------------------------------------------------------------------------
// Grid route cost package
// Widths, register codes, reset values and control bundles.
// ---------------------------------------------------------------------------
package grc_pkg;

  localparam int MAX_SIDE  = 32;
  localparam int SIDE_W    = 6;
  localparam int COST_W    = 10;
  localparam int OUT_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER   = 2'd2;

  localparam logic [SIDE_W-1:0] SIDE_RST     = 6'd32;
  localparam logic [COST_W-1:0] STRAIGHT_RST = 10'd100;
  localparam logic [COST_W-1:0] CORNER_RST   = 10'd500;
  localparam logic [OUT_W-1:0]  COST_MAX     = 20'hFFFFF;

  localparam logic [1:0] DIR_E = 2'd0;
  localparam logic [1:0] DIR_W = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_N = 2'd3;

  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic init;
    logic nb_skip;
    logic nb_issue;
    logic relax;
    logic pop;
    logic src_rd;
    logic base_lat;
    logic fin_start;
    logic fin_issue;
    logic fin_acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic nb_ok;
    logic e_last;
    logic q_empty;
    logic src_goal;
    logic fin_last;
    logic out_free;
  } sts_t;

  function automatic logic [OUT_W-1:0] sat_add(input logic [OUT_W-1:0] a,
                                               input logic [COST_W-1:0] b);
    logic [OUT_W:0] s;
    s = {1'b0, a} + (OUT_W+1)'(b);
    return s[OUT_W] ? COST_MAX : s[OUT_W-1:0];
  endfunction

endpackage

/* design/grc_if.sv */
// ---------------------------------------------------------------------------
// Grid route cost stream interfaces
// Cell input channel and result output channel.
// ---------------------------------------------------------------------------
interface grc_in_if;
  logic valid;
  logic ready;
  logic cell_blocked;
  logic last_cell;
  modport source (output valid, cell_blocked, last_cell, input ready);
  modport sink (input valid, cell_blocked, last_cell, output ready);
endinterface

interface grc_out_if;
  logic                       valid;
  logic                       ready;
  logic [grc_pkg::OUT_W-1:0]  min_cost;
  logic                       reachable;
  modport source (output valid, min_cost, reachable, input ready);
  modport sink (input valid, min_cost, reachable, output ready);
endinterface

/* design/grc_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/grc_ctrl.sv */
// ---------------------------------------------------------------------------
// Grid route cost controller
// Sequences cell load, store clear, route relaxation and result hand-off.
// ---------------------------------------------------------------------------
module grc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_cell_i,
  input  grc_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output grc_pkg::cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_NB   = 4'd2;
  localparam logic [3:0] ST_CHK  = 4'd3;
  localparam logic [3:0] ST_NEXT = 4'd4;
  localparam logic [3:0] ST_SRC  = 4'd5;
  localparam logic [3:0] ST_BASE = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_FACC = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && last_cell_i) begin
          cmd_o.clr_start = 1'b1;
          state_d         = ST_CLR;
        end
      end
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.init = 1'b1;
          state_d    = ST_NB;
        end
      end
      ST_NB: begin
        if (sts_i.nb_ok) begin
          cmd_o.nb_issue = 1'b1;
          state_d        = ST_CHK;
        end else begin
          cmd_o.nb_skip = 1'b1;
          if (sts_i.e_last) begin
            state_d = ST_NEXT;
          end
        end
      end
      ST_CHK: begin
        cmd_o.relax = 1'b1;
        state_d     = sts_i.e_last ? ST_NEXT : ST_NB;
      end
      ST_NEXT: begin
        if (sts_i.q_empty) begin
          cmd_o.fin_start = 1'b1;
          state_d         = ST_FIN;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_SRC;
        end
      end
      ST_SRC: begin
        cmd_o.src_rd = 1'b1;
        state_d      = ST_BASE;
      end
      ST_BASE: begin
        cmd_o.base_lat = 1'b1;
        state_d        = sts_i.src_goal ? ST_NEXT : ST_NB;
      end
      ST_FIN: begin
        cmd_o.fin_issue = 1'b1;
        state_d         = ST_FACC;
      end
      ST_FACC: begin
        cmd_o.fin_acc = 1'b1;
        state_d       = sts_i.fin_last ? ST_DONE : ST_FIN;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/grc_dp.sv */
// ---------------------------------------------------------------------------
// Grid route cost datapath
// Wall map, per-state cost store, work queue and relaxation arithmetic.
// ---------------------------------------------------------------------------
module grc_dp #(
  parameter int MAX_SIDE = grc_pkg::MAX_SIDE
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  grc_pkg::cmd_t                   cmd_i,
  input  logic                            cell_blocked_i,
  input  logic                            cfg_we_i,
  input  logic [grc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [grc_pkg::COST_W-1:0]      cfg_data_i,
  input  logic                            out_ready_i,
  output grc_pkg::sts_t                   sts_o,
  output logic                            out_valid_o,
  output logic [grc_pkg::OUT_W-1:0]       min_cost_o,
  output logic                            reachable_o
);

  localparam int RW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CW = 2 * RW;
  localparam int AW = CW + 2;
  localparam int LW = 2 * RW + 2;
  localparam int OW = grc_pkg::OUT_W;

  logic [grc_pkg::SIDE_W-1:0] side_q;
  logic [grc_pkg::COST_W-1:0] straight_q, corner_q;
  logic [RW:0]                n_w, nm1_w;

  logic [RW:0]   row_q;
  logic [RW-1:0] col_q;
  logic [AW-1:0] clr_q;
  logic [RW-1:0] cur_r_q, cur_c_q;
  logic [1:0]    cur_d_q, e_q, fe_q;
  logic          start_q;
  logic [OW-1:0] base_q, best_q;
  logic          found_q;
  logic [AW-1:0] head_q, tail_q, t_q;
  logic [AW:0]   cnt_q;

  logic [RW:0]   nr_w, nc_w;
  logic          nb_ok_w;
  logic [AW-1:0] nb_addr_w, goal_addr_w;
  logic [OW-1:0] cand_w, step_w;
  logic          upd_w, push_w;

  logic          wall_we, wall_rd;
  logic [CW-1:0] wall_waddr, wall_raddr;
  logic [LW-1:0] wall_wlin_w, wall_rlin_w;
  logic          cost_we;
  logic [AW-1:0] cost_waddr, cost_raddr;
  logic [OW:0]   cost_wdata, cost_rd;
  logic          qd_we, qd_wdata, qd_rd;
  logic [AW-1:0] qd_waddr;
  logic [AW-1:0] q_rd;

  always_comb begin
    if ({1'b0, side_q} < 7'd2) begin
      n_w = (RW+1)'(2);
    end else if (7'({1'b0, side_q}) > 7'(MAX_SIDE)) begin
      n_w = (RW+1)'(MAX_SIDE);
    end else begin
      n_w = (RW+1)'(side_q);
    end
  end
  assign nm1_w = n_w - (RW+1)'(1);

  always_comb begin
    nr_w    = {1'b0, cur_r_q};
    nc_w    = {1'b0, cur_c_q};
    nb_ok_w = 1'b0;
    case (e_q)
      grc_pkg::DIR_E: begin
        nc_w    = {1'b0, cur_c_q} + (RW+1)'(1);
        nb_ok_w = nc_w < n_w;
      end
      grc_pkg::DIR_W: begin
        nc_w    = {1'b0, cur_c_q} - (RW+1)'(1);
        nb_ok_w = cur_c_q != '0;
      end
      grc_pkg::DIR_S: begin
        nr_w    = {1'b0, cur_r_q} + (RW+1)'(1);
        nb_ok_w = nr_w < n_w;
      end
      grc_pkg::DIR_N: begin
        nr_w    = {1'b0, cur_r_q} - (RW+1)'(1);
        nb_ok_w = cur_r_q != '0;
      end
      default: begin
        nb_ok_w = 1'b0;
      end
    endcase
  end

  assign nb_addr_w   = {nr_w[RW-1:0], nc_w[RW-1:0], e_q};
  assign goal_addr_w = {nm1_w[RW-1:0], nm1_w[RW-1:0], fe_q};

  assign step_w = grc_pkg::sat_add(base_q, straight_q);
  assign cand_w = (start_q || (e_q == cur_d_q)) ? step_w
                                                : grc_pkg::sat_add(step_w, corner_q);
  assign upd_w  = cmd_i.relax && !wall_rd && (!cost_rd[OW] || (cand_w < cost_rd[OW-1:0]));
  assign push_w = upd_w && !qd_rd;

  // wall map is addressed by the linear load position row * side + column
  assign wall_wlin_w = LW'(row_q[RW-1:0]) * LW'(n_w) + LW'(col_q);
  assign wall_rlin_w = LW'(nr_w[RW-1:0]) * LW'(n_w) + LW'(nc_w[RW-1:0]);
  assign wall_waddr  = wall_wlin_w[CW-1:0];
  assign wall_raddr  = wall_rlin_w[CW-1:0];

  assign wall_we    = cmd_i.load && (row_q < n_w);

  assign cost_we    = cmd_i.clr_step || upd_w;
  assign cost_waddr = cmd_i.clr_step ? clr_q : t_q;
  assign cost_wdata = cmd_i.clr_step ? '0 : {1'b1, cand_w};
  assign cost_raddr = cmd_i.src_rd ? q_rd : (cmd_i.fin_issue ? goal_addr_w : nb_addr_w);

  assign qd_we    = cmd_i.clr_step || cmd_i.src_rd || push_w;
  assign qd_waddr = cmd_i.clr_step ? clr_q : (cmd_i.src_rd ? q_rd : t_q);
  assign qd_wdata = push_w;

  grc_ram #(.WIDTH(1), .DEPTH(2**CW)) u_wall (
    .clk_i   (clk_i),
    .we_i    (wall_we),
    .waddr_i (wall_waddr),
    .wdata_i (cell_blocked_i),
    .raddr_i (wall_raddr),
    .rdata_o (wall_rd)
  );

  grc_ram #(.WIDTH(OW+1), .DEPTH(2**AW)) u_cost (
    .clk_i   (clk_i),
    .we_i    (cost_we),
    .waddr_i (cost_waddr),
    .wdata_i (cost_wdata),
    .raddr_i (cost_raddr),
    .rdata_o (cost_rd)
  );

  grc_ram #(.WIDTH(1), .DEPTH(2**AW)) u_queued (
    .clk_i   (clk_i),
    .we_i    (qd_we),
    .waddr_i (qd_waddr),
    .wdata_i (qd_wdata),
    .raddr_i (nb_addr_w),
    .rdata_o (qd_rd)
  );

  grc_ram #(.WIDTH(AW), .DEPTH(2**AW)) u_queue (
    .clk_i   (clk_i),
    .we_i    (push_w),
    .waddr_i (tail_q),
    .wdata_i (t_q),
    .raddr_i (head_q),
    .rdata_o (q_rd)
  );

  assign sts_o.clr_last = &clr_q;
  assign sts_o.nb_ok    = nb_ok_w;
  assign sts_o.e_last   = e_q == grc_pkg::DIR_N;
  assign sts_o.q_empty  = cnt_q == '0;
  assign sts_o.src_goal = ({1'b0, cur_r_q} == nm1_w) && ({1'b0, cur_c_q} == nm1_w);
  assign sts_o.fin_last = fe_q == grc_pkg::DIR_N;
  assign sts_o.out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= grc_pkg::SIDE_RST;
      straight_q  <= grc_pkg::STRAIGHT_RST;
      corner_q    <= grc_pkg::CORNER_RST;
      row_q       <= '0;
      col_q       <= '0;
      clr_q       <= '0;
      e_q         <= '0;
      fe_q        <= '0;
      start_q     <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          grc_pkg::CFG_SIDE:     side_q     <= cfg_data_i[grc_pkg::SIDE_W-1:0];
          grc_pkg::CFG_STRAIGHT: straight_q <= cfg_data_i;
          grc_pkg::CFG_CORNER:   corner_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_start) begin
        row_q <= '0;
        col_q <= '0;
        clr_q <= '0;
      end else if (wall_we) begin
        if ({1'b0, col_q} == nm1_w) begin
          col_q <= '0;
          row_q <= row_q + (RW+1)'(1);
        end else begin
          col_q <= col_q + RW'(1);
        end
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.init) begin
        start_q <= 1'b1;
        e_q     <= '0;
        head_q  <= '0;
        tail_q  <= '0;
        cnt_q   <= '0;
      end
      if (cmd_i.nb_skip || cmd_i.relax) begin
        e_q <= e_q + 2'd1;
      end
      if (push_w) begin
        tail_q <= tail_q + AW'(1);
        cnt_q  <= cnt_q + (AW+1)'(1);
      end
      if (cmd_i.pop) begin
        head_q <= head_q + AW'(1);
        cnt_q  <= cnt_q - (AW+1)'(1);
      end
      if (cmd_i.base_lat) begin
        start_q <= 1'b0;
        e_q     <= '0;
      end
      if (cmd_i.fin_start) begin
        fe_q    <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.fin_acc) begin
        fe_q <= fe_q + 2'd1;
        if (cost_rd[OW]) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      cur_r_q <= '0;
      cur_c_q <= '0;
      cur_d_q <= grc_pkg::DIR_E;
      base_q  <= '0;
    end
    if (cmd_i.nb_issue) begin
      t_q <= nb_addr_w;
    end
    if (cmd_i.src_rd) begin
      cur_r_q <= q_rd[AW-1:RW+2];
      cur_c_q <= q_rd[RW+1:2];
      cur_d_q <= q_rd[1:0];
    end
    if (cmd_i.base_lat) begin
      base_q <= cost_rd[OW-1:0];
    end
    if (cmd_i.fin_start) begin
      best_q <= grc_pkg::COST_MAX;
    end
    if (cmd_i.fin_acc && cost_rd[OW] && (!found_q || (cost_rd[OW-1:0] < best_q))) begin
      best_q <= cost_rd[OW-1:0];
    end
    if (cmd_i.out_load) begin
      min_cost_o  <= found_q ? best_q : grc_pkg::COST_MAX;
      reachable_o <= found_q;
    end
  end

endmodule

/* design/grid_route_cost_with_turn_penalty.sv */
// ---------------------------------------------------------------------------
// Grid route cost with turn penalty
// Loads a wall map one cell per beat, then finds the cheapest route cost.
// ---------------------------------------------------------------------------
// Cells: one beat per cycle; the wall map write is the only work per cell.
// Search after the last cell: the cost store is cleared entry by entry (4096
// entries at MAX_SIDE 32), then each dequeued route state is expanded to its
// in-grid neighbors, then the goal states are read and the result handed off.
// Input ready is low from the last cell until the result enters the output
// register. Reset clears control, queue and load position; configuration
// returns to side 32, straight cost 100, corner cost 500.
module grid_route_cost_with_turn_penalty #(
  parameter int MAX_SIDE = grc_pkg::MAX_SIDE
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  grc_in_if.sink                        in_i,
  grc_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [grc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [grc_pkg::COST_W-1:0]    cfg_data_i
);

  grc_pkg::cmd_t cmd;
  grc_pkg::sts_t sts;

  grc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .last_cell_i (in_i.last_cell),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  grc_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cell_blocked_i (in_i.cell_blocked),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (out_o.ready),
    .sts_o          (sts),
    .out_valid_o    (out_o.valid),
    .min_cost_o     (out_o.min_cost),
    .reachable_o    (out_o.reachable)
  );

endmodule

/* design/grc_checker.sv */
// ---------------------------------------------------------------------------
// Grid route cost checker
// Port-level properties, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "grid_route_cost_with_turn_penalty_defines.svh"

module grc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      last_cell_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [grc_pkg::OUT_W-1:0] min_cost_i,
  input logic                      reachable_i
);

  `GRC_ASSERT_IMP(a_unreach_max, clk_i, rst_ni, out_valid_i && !reachable_i, min_cost_i == grc_pkg::COST_MAX)
  `GRC_ASSERT_NXT(a_last_stalls_in, clk_i, rst_ni, in_valid_i && in_ready_i && last_cell_i, !in_ready_i)
  `GRC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(min_cost_i) && $stable(reachable_i))

endmodule

bind grid_route_cost_with_turn_penalty grc_checker u_grc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .last_cell_i (in_i.last_cell),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .min_cost_i  (out_o.min_cost),
  .reachable_i (out_o.reachable)
);

/* test/grid_route_cost_with_turn_penalty_test.sv */
// ---------------------------------------------------------------------------
// Grid route cost with turn penalty testbench
// Streams wall maps into the block, predicts the cheapest turn-penalized route
// per grid with an in-bench search, and checks each result beat in order.
// ---------------------------------------------------------------------------
module grid_route_cost_with_turn_penalty_test;

  localparam int CELL_N   = grc_pkg::MAX_SIDE * grc_pkg::MAX_SIDE;
  localparam int STATE_N  = CELL_N * 4;
  localparam int WD_LIMIT = 300000;
  localparam int SETTLE   = 20;
  localparam int ITEMS    = 1400;

  typedef struct packed {
    logic blocked;
    logic last;
  } cell_beat_t;

  typedef struct packed {
    logic [grc_pkg::OUT_W-1:0] cost;
    logic                      reach;
  } route_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [grc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [grc_pkg::COST_W-1:0] cfg_data_i;

  grc_in_if  cell_if ();
  grc_out_if res_if ();

  grid_route_cost_with_turn_penalty dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (cell_if),
    .out_o     (res_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cell_beat_t cell_q[$];
  route_res_t route_exp_q[$];
  int err_cnt = 0;
  int cells_sent = 0;
  int cells_queued = 0;
  int grids_sent = 0;
  int routes_seen = 0;
  int idle_cycles = 0;

  // predictor state
  logic [grc_pkg::SIDE_W-1:0] side_reg = grc_pkg::SIDE_RST;
  logic [grc_pkg::COST_W-1:0] straight_reg = grc_pkg::STRAIGHT_RST;
  logic [grc_pkg::COST_W-1:0] corner_reg = grc_pkg::CORNER_RST;
  bit wall_q[CELL_N];
  int load_pos = 0;
  int unsigned best_q[STATE_N];
  bit seen_q[STATE_N];
  bit inq_q[STATE_N];
  int work_q[$];
  const int step_r[4] = '{0, 0, 1, -1};
  const int step_c[4] = '{1, -1, 0, 0};

  function automatic int side_eff();
    if (side_reg < 2) return 2;
    if (side_reg > grc_pkg::MAX_SIDE) return grc_pkg::MAX_SIDE;
    return side_reg;
  endfunction

  function automatic int unsigned cost_add(int unsigned a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > grc_pkg::COST_MAX) ? grc_pkg::COST_MAX : s;
  endfunction

  function automatic bit open_cell(int r, int c, int n);
    if (r < 0 || c < 0 || r >= n || c >= n) return 1'b0;
    return !wall_q[r * n + c];
  endfunction

  function automatic void relax_state(int s, int unsigned cost);
    if (!seen_q[s] || cost < best_q[s]) begin
      seen_q[s] = 1'b1;
      best_q[s] = cost;
      if (!inq_q[s]) begin
        inq_q[s] = 1'b1;
        work_q.push_back(s);
      end
    end
  endfunction

  function automatic route_res_t route_search();
    int n, goal, s, cidx, d, r, c, nr, nc;
    int unsigned cost, best;
    bit found;
    route_res_t res;
    n = side_eff();
    goal = n * n - 1;
    best = grc_pkg::COST_MAX;
    found = 1'b0;
    for (int i = 0; i < STATE_N; i++) begin
      seen_q[i] = 1'b0;
      inq_q[i] = 1'b0;
      best_q[i] = 0;
    end
    work_q.delete();
    for (int e = 0; e < 4; e++)
      if (open_cell(step_r[e], step_c[e], n))
        relax_state((step_r[e] * n + step_c[e]) * 4 + e, cost_add(0, straight_reg));
    while (work_q.size() > 0) begin
      s = work_q.pop_front();
      inq_q[s] = 1'b0;
      cidx = s >> 2;
      d = s & 3;
      if (cidx == goal) continue;
      r = cidx / n;
      c = cidx % n;
      for (int e = 0; e < 4; e++) begin
        nr = r + step_r[e];
        nc = c + step_c[e];
        if (!open_cell(nr, nc, n)) continue;
        cost = cost_add(best_q[s], straight_reg);
        if (e != d) cost = cost_add(cost, corner_reg);
        relax_state((nr * n + nc) * 4 + e, cost);
      end
    end
    for (int e = 0; e < 4; e++)
      if (seen_q[goal * 4 + e]) begin
        if (!found || best_q[goal * 4 + e] < best) best = best_q[goal * 4 + e];
        found = 1'b1;
      end
    res.cost = found ? best[grc_pkg::OUT_W-1:0] : grc_pkg::COST_MAX;
    res.reach = found;
    return res;
  endfunction

  function automatic void load_cell(cell_beat_t b);
    int total;
    total = side_eff() * side_eff();
    if (load_pos < total) begin
      wall_q[load_pos] = b.blocked;
      load_pos++;
    end
    if (b.last) begin
      route_exp_q.push_back(route_search());
      load_pos = 0;
    end
  endfunction

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // driver
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cell_if.valid <= 1'b0;
    end else begin
      if (cell_if.valid && cell_if.ready) begin
        load_cell('{blocked: cell_if.cell_blocked, last: cell_if.last_cell});
        cells_sent++;
      end
      if (!(cell_if.valid && !cell_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          cell_if.valid <= 1'b0;
        end else if (cell_q.size() > 0) begin
          cell_beat_t b;
          b = cell_q.pop_front();
          cell_if.valid <= 1'b1;
          cell_if.cell_blocked <= b.blocked;
          cell_if.last_cell <= b.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
          end
        end else begin
          cell_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  int stall_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(200, 20000);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (stall_mode == 1 && $urandom_range(0, 1) == 0) begin
      res_if.ready <= 1'b0;
    end else if (stall_mode == 2 && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 30);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      route_res_t want;
      routes_seen++;
      if (route_exp_q.size() == 0) begin
        report($sformatf("unexpected result cost=%0d reach=%0b",
                         res_if.min_cost, res_if.reachable));
      end else begin
        want = route_exp_q.pop_front();
        if (res_if.min_cost !== want.cost)
          report($sformatf("min_cost got %0d want %0d", res_if.min_cost, want.cost));
        if (res_if.reachable !== want.reach)
          report($sformatf("reachable got %0b want %0b", res_if.reachable, want.reach));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((cell_if.valid && cell_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("grid_route_cost_with_turn_penalty_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_reg(logic [grc_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[grc_pkg::COST_W-1:0];
    if (idx == grc_pkg::CFG_SIDE) side_reg = val[grc_pkg::SIDE_W-1:0];
    else if (idx == grc_pkg::CFG_STRAIGHT) straight_reg = val[grc_pkg::COST_W-1:0];
    else if (idx == grc_pkg::CFG_CORNER) corner_reg = val[grc_pkg::COST_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(int unsigned side, int unsigned st, int unsigned co);
    set_reg(grc_pkg::CFG_SIDE, side);
    set_reg(grc_pkg::CFG_STRAIGHT, st);
    set_reg(grc_pkg::CFG_CORNER, co);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cell_q.size() > 0 || cell_if.valid || route_exp_q.size() > 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // shape: 0 random walls, 1 serpentine; start_wall / goal_wall force corners
  task automatic queue_grid(int shape, int pct, int count, int start_wall, int goal_wall);
    int n, r, c;
    cell_beat_t b;
    n = side_eff();
    for (int i = 0; i < count; i++) begin
      r = i / n;
      c = i % n;
      if (shape == 1 && i < n * n)
        b.blocked = (r % 2 == 1) && (c != ((r % 4 == 1) ? n - 1 : 0));
      else
        b.blocked = ($urandom_range(0, 99) < pct);
      if (i == 0 && start_wall >= 0) b.blocked = start_wall[0];
      if (i == n * n - 1 && goal_wall >= 0) b.blocked = goal_wall[0];
      b.last = (i == count - 1);
      cell_q.push_back(b);
    end
    cells_queued += count;
    grids_sent++;
  endtask

  function automatic int unsigned pick_cost();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1023;
      2: return $urandom_range(0, 15);
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  initial begin
    int n, cnt, pct, budget;
    cell_if.valid = 1'b0;
    cell_if.cell_blocked = 1'b0;
    cell_if.last_cell = 1'b0;
    res_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = grc_pkg::CFG_SIDE;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // full map at reset settings, mostly walls
    queue_grid(0, 88, CELL_N, 0, -1);
    wait_idle();
    set_all(2, 1023, 1023);
    queue_grid(0, 0, 4, 0, 0);
    queue_grid(0, 0, 4, 1, 0);
    queue_grid(0, 100, 4, 0, -1);
    queue_grid(0, 0, 4, 0, 1);
    wait_idle();
    set_all(3, 0, 0);
    queue_grid(0, 0, 9, 0, 0);
    queue_grid(0, 30, 12, -1, -1);
    wait_idle();
    set_all(4, 7, 1);
    queue_grid(0, 20, 5, -1, -1);
    queue_grid(0, 0, 16, 0, 0);
    wait_idle();
    set_all(0, 1, 1023);
    queue_grid(0, 0, 4, 0, 0);
    wait_idle();
    set_all(1, 1023, 0);
    queue_grid(0, 50, 6, -1, -1);
    wait_idle();
    // clamped large sides with short maps over the earlier walls
    set_all(63, 1023, 1023);
    queue_grid(1, 0, 64, 0, -1);
    wait_idle();
    set_all(40, 1, 2);
    queue_grid(0, 92, 64, 0, -1);
    wait_idle();

    budget = ITEMS - cells_queued;
    while (budget > 0) begin
      case ($urandom_range(0, 9))
        0, 1:    n = $urandom_range(6, 10);
        default: n = $urandom_range(2, 5);
      endcase
      if ($urandom_range(0, 19) == 0) n = $urandom_range(0, 1);
      set_all(n, pick_cost(), pick_cost());
      n = side_eff();
      repeat ($urandom_range(1, 4)) begin
        pct = $urandom_range(0, 45);
        cnt = n * n;
        case ($urandom_range(0, 9))
          0: cnt = cnt + $urandom_range(1, 6);
          1: cnt = $urandom_range(1, cnt);
          default: ;
        endcase
        queue_grid(0, pct, cnt, ($urandom_range(0, 7) == 0) ? 1 : -1, -1);
        budget -= cnt;
      end
      wait_idle();
    end

    $display("covered %0d grids over %0d cell beats, %0d route results checked",
             grids_sent, cells_sent, routes_seen);
    $display("sides 0..63 incl. clamped, costs 0..1023, walled start/goal, short/long maps");
    if (err_cnt == 0) begin
      $display("grid_route_cost_with_turn_penalty_test: done, clean");
    end else begin
      $display("grid_route_cost_with_turn_penalty_test: done, errors");
    end
    $finish;
  end

endmodule
